### rtl/cua_pkg.sv
// Shared types and constants for the CPU utilization averager.
`timescale 1ns / 1ps
package cua_pkg;

	localparam int TIME_W     = 63;            // counter width
	localparam int DVS_W      = 64;            // divisor and delta-sum width
	localparam int DVD_W      = DVS_W + 7;     // dividend width, holds delta * 100
	localparam int CNT_W      = $clog2(DVD_W + 1);
	localparam int Q_W        = 10;            // quotient bits kept before saturation
	localparam int SYS_W      = 7;
	localparam int PROC_W     = 10;
	localparam int PROC_MAX   = 1023;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int WINDOW_DEF = 5;
	localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 32'd2000000;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYS_PRESENT  = 1'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_SUMS,
		ST_DECIDE,
		ST_SETUP,
		ST_MUL1,
		ST_MUL2,
		ST_AVG_LOAD,
		ST_DIV,
		ST_STORE,
		ST_RING,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	// Which quantity the shared divider is working on
	typedef enum logic [1:0] {
		OP_SYS,
		OP_PROC,
		OP_AVG_S,
		OP_AVG_P
	} op_t;

	typedef struct packed {
		logic capture;
		logic delta;
		logic sums;
		logic base_commit;
		logic commit_prev;
		logic setup;
		logic mul1;
		logic mul2;
		logic avg_load;
		logic div_step;
		logic store;
		logic ring_write;
		logic sweep_step;
		logic out_load;
		logic out_updated;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic baseline;
		logic throttle;
		logic div_last;
		logic sweep_last;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/cua_div.sv
// Restoring serial divider, one quotient bit per cycle while step is high, saturating quotient.
`timescale 1ns / 1ps
module cua_div import cua_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             step,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	input  logic [CNT_W-1:0] count,
	output logic             last,
	output logic [Q_W-1:0]   quot
);

	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [Q_W-1:0]   q_q;
	logic             ovf_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] diff;
	logic             ge;

	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = ~diff[DVS_W+1];
	assign last   = (cnt_q == CNT_W'(1));
	assign quot   = ovf_q ? Q_W'(PROC_MAX) : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= count;
		end else if (step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			q_q   <= {q_q[Q_W-2:0], ge};
			// a bit shifted out of the kept quotient means saturate
			ovf_q <= ovf_q | q_q[Q_W-1];
		end
	end

endmodule

### rtl/cua_dpath.sv
// Datapath: sample and baseline counters, deltas, rings, averaging, result register.
`timescale 1ns / 1ps
module cua_dpath import cua_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic [TIME_W-1:0] wall_time,
	input  logic [TIME_W-1:0] idle_time,
	input  logic [TIME_W-1:0] kernel_time,
	input  logic [TIME_W-1:0] user_time,
	input  logic [TIME_W-1:0] proc_kernel_time,
	input  logic [TIME_W-1:0] proc_user_time,
	input  logic              cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [SYS_W-1:0]  system_usage,
	output logic [PROC_W-1:0] process_usage,
	output logic              updated
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(WINDOW * PROC_MAX + 1);

	// configuration
	logic [CFG_W-1:0] min_interval_q;
	logic             sys_present_q;

	// captured sample
	logic [TIME_W-1:0] smp_wall_q, smp_idle_q, smp_kern_q, smp_user_q, smp_pk_q, smp_pu_q;
	// baseline
	logic [TIME_W-1:0] prev_wall_q, prev_idle_q, prev_kern_q, prev_user_q, prev_pk_q, prev_pu_q;
	// deltas
	logic [TIME_W-1:0] d_wall_q, d_idle_q, d_kern_q, d_user_q, d_pk_q, d_pu_q;
	logic [DVS_W-1:0]  sys_q, pd_q;

	// divider operands
	logic [DVS_W-1:0]  num_q;
	logic [DVS_W-1:0]  div_by_q;
	logic              zero_q;
	logic [DVD_W-1:0]  prod_q;

	logic [SYS_W-1:0]  sys_pct_q, last_sys_q;
	logic [PROC_W-1:0] proc_pct_q, last_proc_q;

	logic [SYS_W-1:0]  sys_ring_q  [WINDOW];
	logic [PROC_W-1:0] proc_ring_q [WINDOW];
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] idx_q;
	logic [SUM_W-1:0]  ssum_q, psum_q;

	logic [SYS_W-1:0]  res_sys_q;
	logic [PROC_W-1:0] res_proc_q;
	logic              res_upd_q;
	logic              out_valid_q;

	logic [DVS_W:0]    idle_sub;
	logic              div_load;
	logic [DVD_W-1:0]  div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	logic [CNT_W-1:0]  div_count;
	logic [SUM_W-1:0]  sum_sel;
	logic [Q_W-1:0]    quot;
	logic              div_last;

	assign idle_sub = {1'b0, sys_q} - {2'b00, d_idle_q};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= MIN_INTERVAL_RST;
			sys_present_q  <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MIN_INTERVAL: min_interval_q <= cfg_data;
				REG_SYS_PRESENT:  sys_present_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sample capture, deltas and operand setup
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_wall_q <= wall_time;
			smp_idle_q <= sys_present_q ? idle_time   : '0;
			smp_kern_q <= sys_present_q ? kernel_time : '0;
			smp_user_q <= sys_present_q ? user_time   : '0;
			smp_pk_q   <= proc_kernel_time;
			smp_pu_q   <= proc_user_time;
		end
		if (cmd.delta) begin
			d_wall_q <= smp_wall_q - prev_wall_q;
			d_idle_q <= smp_idle_q - prev_idle_q;
			d_kern_q <= smp_kern_q - prev_kern_q;
			d_user_q <= smp_user_q - prev_user_q;
			d_pk_q   <= smp_pk_q - prev_pk_q;
			d_pu_q   <= smp_pu_q - prev_pu_q;
		end
		if (cmd.sums) begin
			sys_q <= {1'b0, d_user_q} + {1'b0, d_kern_q};
			pd_q  <= {1'b0, d_pu_q} + {1'b0, d_pk_q};
		end
		if (cmd.setup) begin
			if (cmd.op == OP_SYS) begin
				num_q    <= idle_sub[DVS_W-1:0];
				div_by_q <= sys_q;
				// idle above the kernel+user total gives zero, as does an empty total
				zero_q   <= (sys_q == '0) | idle_sub[DVS_W];
			end else begin
				num_q    <= pd_q;
				div_by_q <= {1'b0, d_wall_q};
				zero_q   <= (d_wall_q == '0);
			end
		end
		if (cmd.mul1) begin
			prod_q <= {1'b0, num_q, 6'b0} + {2'b0, num_q, 5'b0};
		end
	end

	// baseline counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_wall_q <= '0;
			prev_idle_q <= '0;
			prev_kern_q <= '0;
			prev_user_q <= '0;
			prev_pk_q   <= '0;
			prev_pu_q   <= '0;
		end else if (cmd.base_commit || cmd.commit_prev) begin
			prev_wall_q <= smp_wall_q;
			prev_idle_q <= smp_idle_q;
			prev_kern_q <= smp_kern_q;
			prev_user_q <= smp_user_q;
			prev_pk_q   <= smp_pk_q;
			prev_pu_q   <= smp_pu_q;
		end
	end

	assign stat.baseline = (prev_wall_q == '0);
	assign stat.throttle = (d_wall_q < {{(TIME_W-CFG_W){1'b0}}, min_interval_q});

	// shared divider: delta*100/total for percentages, sum/fill for means
	assign sum_sel  = (cmd.op == OP_AVG_S) ? ssum_q : psum_q;
	assign div_load = cmd.mul2 | cmd.avg_load;

	always_comb begin
		if (cmd.mul2) begin
			div_dividend = prod_q + {5'b0, num_q, 2'b0};
			div_divisor  = div_by_q;
			div_count    = CNT_W'(DVD_W);
		end else begin
			div_dividend = {sum_sel, {(DVD_W-SUM_W){1'b0}}};
			div_divisor  = DVS_W'(fill_q);
			div_count    = CNT_W'(SUM_W);
		end
	end

	cua_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.step     (cmd.div_step),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.count    (div_count),
		.last     (div_last),
		.quot     (quot)
	);

	assign stat.div_last = div_last;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			case (cmd.op)
				OP_SYS:  sys_pct_q  <= zero_q ? '0 : quot[SYS_W-1:0];
				OP_PROC: proc_pct_q <= zero_q ? '0 : quot;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sys_q  <= '0;
			last_proc_q <= '0;
		end else if (cmd.base_commit) begin
			last_sys_q  <= '0;
			last_proc_q <= '0;
		end else if (cmd.store) begin
			case (cmd.op)
				OP_AVG_S: last_sys_q  <= quot[SYS_W-1:0];
				OP_AVG_P: last_proc_q <= quot;
				default: ;
			endcase
		end
	end

	// rings share one write slot
	always_ff @(posedge clk) begin
		if (cmd.ring_write) begin
			sys_ring_q[slot_q]  <= sys_pct_q;
			proc_ring_q[slot_q] <= proc_pct_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (cmd.ring_write) begin
			slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
			if (fill_q < FILL_W'(WINDOW)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// sweep the filled entries, one per cycle
	always_ff @(posedge clk) begin
		if (cmd.ring_write) begin
			idx_q  <= '0;
			ssum_q <= '0;
			psum_q <= '0;
		end else if (cmd.sweep_step) begin
			idx_q  <= idx_q + FILL_W'(1);
			ssum_q <= ssum_q + SUM_W'(sys_ring_q[idx_q[SLOT_W-1:0]]);
			psum_q <= psum_q + SUM_W'(proc_ring_q[idx_q[SLOT_W-1:0]]);
		end
	end

	assign stat.sweep_last = (FILL_W'(idx_q + FILL_W'(1)) == fill_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_sys_q  <= last_sys_q;
			res_proc_q <= last_proc_q;
			res_upd_q  <= cmd.out_updated;
		end
	end

	assign stat.out_free  = ~out_valid_q | out_ready;
	assign out_valid      = out_valid_q;
	assign system_usage   = res_sys_q;
	assign process_usage  = res_proc_q;
	assign updated        = res_upd_q;

endmodule

### rtl/cua_ctrl.sv
// Controller: one sample's deltas, then unless baseline/throttled: divides, ring, means.
`timescale 1ns / 1ps
module cua_ctrl import cua_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   upd_q, upd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SYS;
			upd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			upd_q   <= upd_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		upd_d   = upd_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: state_d = ST_SUMS;
			ST_SUMS:  state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (stat.baseline || stat.throttle) begin
					upd_d   = 1'b0;
					state_d = ST_FINISH;
				end else begin
					upd_d   = 1'b1;
					op_d    = OP_SYS;
					state_d = ST_SETUP;
				end
			end
			ST_SETUP:    state_d = ST_MUL1;
			ST_MUL1:     state_d = ST_MUL2;
			ST_MUL2:     state_d = ST_DIV;
			ST_AVG_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (stat.div_last) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				case (op_q)
					OP_SYS: begin
						op_d    = OP_PROC;
						state_d = ST_SETUP;
					end
					OP_PROC:  state_d = ST_RING;
					OP_AVG_S: begin
						op_d    = OP_AVG_P;
						state_d = ST_AVG_LOAD;
					end
					default:  state_d = ST_FINISH;
				endcase
			end
			ST_RING: state_d = ST_SWEEP;
			ST_SWEEP: begin
				if (stat.sweep_last) begin
					op_d    = OP_AVG_S;
					state_d = ST_AVG_LOAD;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.op   = op_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DELTA: cmd.delta = 1'b1;
			ST_SUMS:  cmd.sums  = 1'b1;
			ST_DECIDE: begin
				if (stat.baseline) begin
					cmd.base_commit = 1'b1;
				end else if (!stat.throttle) begin
					cmd.commit_prev = 1'b1;
				end
			end
			ST_SETUP:    cmd.setup      = 1'b1;
			ST_MUL1:     cmd.mul1       = 1'b1;
			ST_MUL2:     cmd.mul2       = 1'b1;
			ST_AVG_LOAD: cmd.avg_load   = 1'b1;
			ST_DIV:      cmd.div_step   = 1'b1;
			ST_STORE:    cmd.store      = 1'b1;
			ST_RING:     cmd.ring_write = 1'b1;
			ST_SWEEP:    cmd.sweep_step = 1'b1;
			ST_FINISH: begin
				cmd.out_load    = stat.out_free;
				cmd.out_updated = upd_q;
			end
			default: ;
		endcase
	end

endmodule

### rtl/cpu_utilization_averager.sv
// CPU utilization averager: top level joining controller and datapath.
// One sample is taken at a time; in_ready is high only while the block is idle,
// and a finished result waits in the output register so the next sample can be
// taken before it is read. A baseline or throttled sample goes through the delta,
// sum and decide states to the finish state, which loads the result once the
// output register is free. A computed sample also runs both percentages through
// the single shared restoring divider, writes the rings, sweeps the fill entries in
// use (at most WINDOW) and divides each ring sum, SUM_W bits wide (13 bits for
// WINDOW = 5), by fill in the same divider to get the means.
`timescale 1ns / 1ps
module cpu_utilization_averager import cua_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_W-1:0]    wall_time,
	input  logic [TIME_W-1:0]    idle_time,
	input  logic [TIME_W-1:0]    kernel_time,
	input  logic [TIME_W-1:0]    user_time,
	input  logic [TIME_W-1:0]    proc_kernel_time,
	input  logic [TIME_W-1:0]    proc_user_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SYS_W-1:0]     system_usage,
	output logic [PROC_W-1:0]    process_usage,
	output logic                 updated,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cua_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cua_dpath #(
		.WINDOW (WINDOW)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.wall_time        (wall_time),
		.idle_time        (idle_time),
		.kernel_time      (kernel_time),
		.user_time        (user_time),
		.proc_kernel_time (proc_kernel_time),
		.proc_user_time   (proc_user_time),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.system_usage     (system_usage),
		.process_usage    (process_usage),
		.updated          (updated)
	);

endmodule

### rtl/cua_checker.sv
// Port-level checks for the CPU utilization averager, bound to the top level.
`timescale 1ns / 1ps
module cua_checker import cua_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SYS_W-1:0]  system_usage,
	input logic [PROC_W-1:0] process_usage,
	input logic              updated
);

	// a waiting result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(system_usage)
			&& $stable(process_usage) && $stable(updated))
		else $error("result changed while stalled");

	a_sys_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> system_usage <= SYS_W'(100))
		else $error("system usage above 100");

	// one sample at a time: intake closes right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("intake stayed open after a transfer");

	// a new result only appears while a sample is in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind cpu_utilization_averager cua_checker u_cua_checker (.*);
